// ===== rtl/core/plw_pkg.sv =====
// shared types and constants for the phy link watchdog
package plw_pkg;

  localparam int TIME_WIDTH = 32;

  localparam logic [7:0] ST_AUTO = 8'h86;
  localparam logic [7:0] ST_SLOW = 8'h06;
  localparam logic [7:0] ST_DOWN = 8'h00;

  localparam logic [15:0] POLL_INTERVAL_RST  = 16'd92;
  localparam logic [7:0]  FALLBACK_LIMIT_RST = 8'd52;
  localparam logic [7:0]  DOWN_LIMIT_RST     = 8'd45;

  typedef enum logic [1:0] {
    CFG_POLL_INTERVAL  = 2'd0,
    CFG_FALLBACK_LIMIT = 2'd1,
    CFG_DOWN_LIMIT     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] tick_now;
    logic [7:0]  phy_status;
  } in_item_t;

  typedef struct packed {
    logic checked;
    logic set_auto_100m;
    logic set_manual_10m;
    logic reset_request;
  } out_item_t;

  typedef struct packed {
    logic [15:0] poll_interval;
    logic [7:0]  fallback_limit;
    logic [7:0]  down_limit;
  } cfg_t;

endpackage

// ===== rtl/core/plw_if.sv =====
// channel interfaces for poll beats, result beats and register writes
interface plw_in_if;
  logic              valid;
  logic              ready;
  plw_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plw_out_if;
  logic               valid;
  logic               ready;
  plw_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface plw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/plw_judge.sv =====
// link state tracking and status evaluation for one poll beat
module plw_judge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               eval_en,
  input  plw_pkg::in_item_t  item,
  input  plw_pkg::cfg_t      cfg,
  output plw_pkg::out_item_t res
);
  import plw_pkg::*;

  logic [TIME_WIDTH-1:0] last_time_r, last_time_nxt;
  logic [7:0]            prev_st_r, prev_st_nxt;
  logic [7:0]            slow_cnt_r, slow_cnt_nxt;
  logic [7:0]            down_cnt_r, down_cnt_nxt;

  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  due;
  logic [7:0]            slow_upd;
  logic [7:0]            down_upd;
  logic [7:0]            st;

  always_comb begin
    now     = TIME_WIDTH'(item.tick_now);
    st      = item.phy_status;
    elapsed = now - last_time_r;
    due     = elapsed >= TIME_WIDTH'(cfg.poll_interval);

    slow_upd = slow_cnt_r;
    down_upd = down_cnt_r;
    if (st == ST_SLOW) begin
      if (prev_st_r == ST_SLOW) begin
        slow_upd = (slow_cnt_r < cfg.fallback_limit) ? slow_cnt_r + 8'd1 : slow_cnt_r;
      end else begin
        slow_upd = '0;
      end
    end else if (st == ST_DOWN) begin
      if (prev_st_r == ST_DOWN) begin
        down_upd = (down_cnt_r < cfg.down_limit) ? down_cnt_r + 8'd1 : down_cnt_r;
      end else begin
        down_upd = '0;
      end
    end else begin
      slow_upd = '0;
      down_upd = '0;
    end

    res.checked        = due;
    res.set_auto_100m  = due && (st == ST_AUTO) && (prev_st_r != ST_AUTO);
    res.set_manual_10m = due && (slow_upd >= cfg.fallback_limit);
    res.reset_request  = due && (down_upd >= cfg.down_limit);

    last_time_nxt = last_time_r;
    prev_st_nxt   = prev_st_r;
    slow_cnt_nxt  = slow_cnt_r;
    down_cnt_nxt  = down_cnt_r;
    if (eval_en && due) begin
      last_time_nxt = now;
      prev_st_nxt   = st;
      slow_cnt_nxt  = res.set_manual_10m ? 8'd0 : slow_upd;
      down_cnt_nxt  = down_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      prev_st_r   <= '0;
      slow_cnt_r  <= '0;
      down_cnt_r  <= '0;
    end else begin
      last_time_r <= last_time_nxt;
      prev_st_r   <= prev_st_nxt;
      slow_cnt_r  <= slow_cnt_nxt;
      down_cnt_r  <= down_cnt_nxt;
    end
  end

  a_manual_clears: assert property (@(posedge clk) disable iff (!rst_n)
    eval_en && res.set_manual_10m |=> slow_cnt_r == 8'd0)
    else $error("slow count not cleared after fallback");

  a_skip_holds: assert property (@(posedge clk) disable iff (!rst_n)
    eval_en && !res.checked |=> $stable(last_time_r) && $stable(prev_st_r)
      && $stable(slow_cnt_r) && $stable(down_cnt_r))
    else $error("state changed on skipped poll");

  a_check_latches: assert property (@(posedge clk) disable iff (!rst_n)
    eval_en && res.checked |=> last_time_r == $past(now) && prev_st_r == $past(st))
    else $error("check time or status not latched");

endmodule

// ===== rtl/core/eth_phy_link_watchdog.sv =====
// top level of the phy link watchdog: input stage, evaluation, result stage
// an accepted poll beat is registered in the input stage, its result in the result stage
// throughput: one poll beat per cycle unless out_bus.ready stalls; one evaluation stage
// while a result waits on out_bus.ready the input stage takes one more beat, then stalls
// reset clears valid flags, check time, last status and both repeat counts,
// and loads the register defaults 92, 52 and 45
module eth_phy_link_watchdog (
  input logic clk,
  input logic rst_n,
  plw_in_if.sink    in_bus,
  plw_out_if.source out_bus,
  plw_cfg_if.sink   cfg_bus
);
  import plw_pkg::*;

  cfg_t      cfg_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  logic      s1_adv;
  logic      eval_en;
  out_item_t res;

  assign s1_adv       = !out_valid_r || out_bus.ready;
  assign eval_en      = s1_valid_r && s1_adv;
  assign in_bus.ready = !s1_valid_r || s1_adv;
  assign cfg_bus.ready = 1'b1;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_interval  <= POLL_INTERVAL_RST;
      cfg_r.fallback_limit <= FALLBACK_LIMIT_RST;
      cfg_r.down_limit     <= DOWN_LIMIT_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        CFG_POLL_INTERVAL:  cfg_r.poll_interval  <= cfg_bus.data;
        CFG_FALLBACK_LIMIT: cfg_r.fallback_limit <= cfg_bus.data[7:0];
        CFG_DOWN_LIMIT:     cfg_r.down_limit     <= cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      s1_item_r <= in_bus.data;
    end
    if (eval_en) begin
      out_item_r <= res;
    end
  end

  plw_judge u_judge (
    .clk     (clk),
    .rst_n   (rst_n),
    .eval_en (eval_en),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.checked |->
      !out_item_r.set_auto_100m && !out_item_r.set_manual_10m && !out_item_r.reset_request)
    else $error("request raised on skipped poll");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a beat");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    eval_en |=> out_valid_r)
    else $error("evaluated beat did not reach result stage");

endmodule
